FILE: rtl/core/inverter_frequency_ramp_control_unit_macros.svh
// assertion macros for the frequency ramp control block
`ifndef INVERTER_FREQUENCY_RAMP_CONTROL_UNIT_MACROS_SVH
`define INVERTER_FREQUENCY_RAMP_CONTROL_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define IFR_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m failed");
// next-cycle implication checked on every rising clock edge outside reset
`define IFR_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m failed");
`endif

FILE: rtl/core/ifrc_pkg.sv
// shared types and constants of the frequency ramp control block
`timescale 1ns / 1ps
package ifrc_pkg;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;

  typedef struct packed {
    logic               braking;
    logic               coasting;
    logic signed [31:0] angular_step;
    logic               rescale_enable;
    logic        [31:0] phase_time_in;
    logic               quit;
  } ifrc_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] control_freq;
    logic [31:0] angular_freq;
    logic [31:0] phase_time_out;
    logic        free_running;
  } ifrc_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item and its phase time
    logic mul_start; // clamp the new angular value
    logic div_start; // form phase * old angular, start the long division
    logic div_step;  // load the dividend, or one quotient bit
    logic update;    // commit angular/control/phase
    logic ramp;      // ramp and flag update
  } ifrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } ifrc_sts_t;
endpackage

FILE: rtl/core/ifrc_datapath.sv
// datapath: angular update, phase rescale divider, control frequency ramp
`timescale 1ns / 1ps
module ifrc_datapath import ifrc_pkg::*; #(
  parameter int unsigned FREQ_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RegIdxW-1:0]  cfg_idx,
  input  logic [31:0]         cfg_data,
  input  ifrc_in_t            item,
  input  ifrc_cmd_t           cmd,
  output ifrc_sts_t           sts,
  output ifrc_out_t           result
);
  localparam logic [32:0] FreqMax = (FREQ_BITS >= 32) ? 33'h0_FFFF_FFFF
                                    : ((33'd1 << FREQ_BITS) - 33'd1);

  logic [31:0] regs [NumRegs];
  ifrc_in_t    it;
  logic [31:0] ang, ctl, new_ang, phase;
  logic        frf;
  logic [63:0] prod, rem_q;   // dividend shifts to quotient
  logic [32:0] rem;
  logic [6:0]  cnt;
  logic [63:0] sf_prod;
  logic [31:0] sf;

  // new angular value, before the clamp
  logic signed [34:0] na;
  assign na = $signed({3'b0, ang}) + 35'(it.angular_step);

  assign sf_prod = 64'(ang) * 64'(InvTwoPiQ32);
  assign sf      = sf_prod[63:32];

  logic [33:0] trial;
  assign trial = {rem, rem_q[63]} - {2'b0, new_ang};

  assign sts.need_div = !frf && it.rescale_enable && (new_ang != '0);
  assign sts.div_done = (cnt == 7'd64);

  logic [2:0]  sel;
  logic [31:0] rate, ceil_v, c_on, c_off;
  logic [32:0] fin;
  assign sel    = {it.braking, it.coasting, 1'b0};
  assign rate   = regs[sel];
  assign ceil_v = regs[sel | 3'd1];

  // throttle on: over the ceiling snaps to the sine frequency
  assign c_on  = (frf && ctl > ceil_v) ? sf : ctl;
  // throttle off: over the ceiling clamps to it
  assign c_off = (frf && ctl > ceil_v) ? ceil_v : ctl;
  assign fin   = 33'(c_on) + 33'(rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
      ang <= '0;
      ctl <= '0;
      frf <= 1'b0;
    end else begin
      if (cfg_we) regs[cfg_idx] <= cfg_data;
      if (cmd.load) begin
        it <= item;
        phase <= item.phase_time_in;
      end
      if (cmd.mul_start) begin
        if (na < 0) new_ang <= '0;
        else if (na > $signed({2'b0, FreqMax})) new_ang <= FreqMax[31:0];
        else new_ang <= na[31:0];
      end
      if (cmd.div_start) begin
        prod  <= 64'(phase) * 64'(ang);
        rem   <= '0;
        cnt   <= '0;
      end
      if (cmd.div_step) begin
        if (cnt == 7'd0) rem_q <= prod;
        else begin
          if (!trial[33]) begin
            rem   <= trial[32:0];
            rem_q <= {rem_q[62:0], 1'b1};
          end else begin
            rem   <= {rem[31:0], rem_q[63]};
            rem_q <= {rem_q[62:0], 1'b0};
          end
        end
        cnt <= cnt + 7'd1;
      end
      if (cmd.update && !frf) begin
        if (it.rescale_enable) begin
          if (new_ang == '0) phase <= '0;
          else phase <= (rem_q[63:32] != '0) ? '1 : rem_q[31:0];
        end
        ctl <= sf;
        ang <= new_ang;
      end
      if (cmd.ramp && !it.quit) begin
        if (!it.coasting) begin
          if (!frf) ctl <= sf;
          else if (33'(sf) <= fin) begin
            ctl <= sf;
            frf <= 1'b0;
          end else begin
            ctl <= fin[31:0];
            frf <= 1'b1;
          end
        end else begin
          ctl <= (c_off > rate) ? c_off - rate : '0;
          frf <= 1'b1;
        end
      end
    end
  end

  assign result.status         = !it.quit;
  assign result.control_freq   = ctl;
  assign result.angular_freq   = ang;
  assign result.phase_time_out = phase;
  assign result.free_running   = frf;
endmodule

FILE: rtl/core/ifrc_ctrl.sv
// controller state machine of the frequency ramp control block
`timescale 1ns / 1ps
module ifrc_ctrl import ifrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ifrc_sts_t sts,
  output ifrc_cmd_t cmd
);
  typedef enum logic [2:0] {IDLE, CLAMP, DSTART, DIV, UPD, RAMP, DONE} st_t;
  st_t st;

  assign in_ready  = (st == IDLE);
  assign out_valid = (st == DONE);

  always_comb begin
    cmd = '0;
    cmd.load      = (st == IDLE) && in_valid;
    cmd.mul_start = (st == CLAMP);
    cmd.div_start = (st == DSTART);
    cmd.div_step  = (st == DIV);
    cmd.update    = (st == UPD);
    cmd.ramp      = (st == RAMP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE;
    end else begin
      unique case (st)
        IDLE:   if (in_valid) st <= CLAMP;
        CLAMP:  st <= DSTART;
        DSTART: st <= sts.need_div ? DIV : UPD;
        DIV:    if (sts.div_done) st <= UPD;
        UPD:    st <= RAMP;
        RAMP:   st <= DONE;
        DONE:   if (out_ready) st <= IDLE;
        default: st <= IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/inverter_frequency_ramp_control_unit.sv
// top level of the inverter frequency ramp control block
`timescale 1ns / 1ps
// one control tick per transfer: the block takes an input item; unless free
// running, it updates the sine angular frequency, clamped to zero and to the
// FREQ_BITS maximum, and if enabled rescales the phase time by old/new angular
// frequency; unless quit is set it ramps or tracks the control frequency. the
// rescale uses a restoring divider giving one quotient bit a cycle over a
// 64-bit dividend. one item is in work at a time; the result is held until
// its transfer out. configuration writes land at once.
module inverter_frequency_ramp_control_unit import ifrc_pkg::*; #(
  parameter int unsigned FREQ_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  ifrc_in_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ifrc_out_t           out_data
);
  ifrc_cmd_t cmd;
  ifrc_sts_t sts;
  logic      we_ok;

  // writes beyond the last register are dropped
  assign we_ok = cfg_we && (cfg_idx < 4'(NumRegs));

  ifrc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  ifrc_datapath #(.FREQ_BITS(FREQ_BITS)) u_dp (
    .clk, .rst, .cfg_we(we_ok), .cfg_idx(cfg_idx[RegIdxW-1:0]), .cfg_data,
    .item(in_data), .cmd, .sts, .result(out_data)
  );
endmodule

FILE: rtl/core/ifrc_checker.sv
// port-level checker for the frequency ramp control block, with its bind
`timescale 1ns / 1ps
`include "inverter_frequency_ramp_control_unit_macros.svh"
module ifrc_checker import ifrc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input ifrc_out_t out_data
);
  `IFR_ASSERT_IMP(a_one_in_flight, clk, rst, out_valid, !in_ready)
  `IFR_ASSERT_NXT(a_in_starts, clk, rst, in_valid && in_ready, !in_ready && !out_valid)
  `IFR_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `IFR_ASSERT_NXT(a_out_once, clk, rst, out_valid && out_ready, !out_valid)
endmodule

bind inverter_frequency_ramp_control_unit ifrc_checker u_ifrc_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

FILE: test/inverter_frequency_ramp_control_unit_tb.sv
// testbench of the inverter frequency ramp control block
`timescale 1ns / 1ps
module inverter_frequency_ramp_control_unit_tb;
  import ifrc_pkg::*;

  localparam logic [3:0] REG_ACCEL_ON_RATE  = 4'd0;
  localparam logic [3:0] REG_ACCEL_ON_MAX   = 4'd1;
  localparam logic [3:0] REG_ACCEL_OFF_RATE = 4'd2;
  localparam logic [3:0] REG_ACCEL_OFF_MAX  = 4'd3;
  localparam logic [3:0] REG_BRAKE_ON_RATE  = 4'd4;
  localparam logic [3:0] REG_BRAKE_ON_MAX   = 4'd5;
  localparam logic [3:0] REG_BRAKE_OFF_RATE = 4'd6;
  localparam logic [3:0] REG_BRAKE_OFF_MAX  = 4'd7;
  localparam logic [3:0] REG_BAD            = 4'd9;
  localparam int         TICK_LATENCY       = 80;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [3:0] cfg_idx;
  logic [31:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  ifrc_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  ifrc_out_t out_data;

  inverter_frequency_ramp_control_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state, mirrors the block registers
  logic [31:0] ramp_regs [8];
  logic [31:0] ang_q;
  logic [31:0] ctl_q;
  logic        frun_q;
  ifrc_out_t   tick_results [$];
  int          errors;

  // idle percentages, hold-off request
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("inverter_frequency_ramp_control_unit_tb failed");
    $finish;
  end

  function automatic logic [31:0] sine_of(logic [31:0] ang);
    logic [63:0] p;
    p = 64'(ang) * 64'(InvTwoPiQ32);
    return p[63:32];
  endfunction

  // one control tick of the predictor
  function automatic ifrc_out_t predict_tick(ifrc_in_t it);
    ifrc_out_t   r;
    logic signed [33:0] na;
    logic [31:0] new_ang, phase, rate, ceil, sf;
    logic [63:0] q;
    logic [32:0] fin;
    int          sel;
    na = $signed({2'b00, ang_q}) + $signed({{2{it.angular_step[31]}}, it.angular_step});
    if (na < 0) na = 0;
    else if (na > 34'sh0_FFFF_FFFF) na = 34'sh0_FFFF_FFFF;
    new_ang = na[31:0];
    phase = it.phase_time_in;
    if (!frun_q) begin
      if (it.rescale_enable) begin
        if (new_ang != 0) begin
          q = (64'(phase) * 64'(ang_q)) / 64'(new_ang);
          phase = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        end else begin
          phase = '0;
        end
      end
      ctl_q = sine_of(ang_q);
      ang_q = new_ang;
    end
    r.status = !it.quit;
    if (!it.quit) begin
      sel = (it.braking ? 4 : 0) + (it.coasting ? 2 : 0);
      rate = ramp_regs[sel];
      ceil = ramp_regs[sel + 1];
      if (!it.coasting) begin
        // throttle on: over the ceiling snaps back to the sine frequency
        if (frun_q && ctl_q > ceil) ctl_q = sine_of(ang_q);
        if (!frun_q) begin
          ctl_q = sine_of(ang_q);
        end else begin
          fin = 33'(ctl_q) + 33'(rate);
          sf = sine_of(ang_q);
          if (33'(sf) <= fin) begin
            ctl_q = sf;
            frun_q = 1'b0;
          end else begin
            ctl_q = fin[31:0];
            frun_q = 1'b1;
          end
        end
      end else begin
        // throttle off: clamp to ceiling, then ramp down floored at zero
        if (frun_q && ctl_q > ceil) ctl_q = ceil;
        ctl_q = (ctl_q > rate) ? ctl_q - rate : '0;
        frun_q = 1'b1;
      end
    end
    r.control_freq = ctl_q;
    r.angular_freq = ang_q;
    r.phase_time_out = phase;
    r.free_running = frun_q;
    return r;
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (idx < 8) ramp_regs[idx[2:0]] = val;
  endtask

  task automatic write_all(logic [31:0] rate, logic [31:0] ceil);
    for (int i = 0; i < 4; i++) begin
      write_reg(4'(2 * i), rate);
      write_reg(4'(2 * i + 1), ceil);
    end
  endtask

  // offer one item and hold it until its transfer; prediction on acceptance
  task automatic send_tick(ifrc_in_t it, bit typed, ifrc_out_t typed_exp);
    ifrc_out_t pr;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pr = predict_tick(it);
    if (typed && pr !== typed_exp) begin
      $error("typed expectation differs from predictor for item %h", it);
      errors++;
    end
    tick_results.push_back(typed ? typed_exp : pr);
    @(negedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (tick_results.size() != 0 && n < 200000) begin
      @(negedge clk);
      n++;
    end
    repeat (TICK_LATENCY) @(negedge clk);
  endtask

  // receiver: random stall, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result checker, one transfer at a time
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (tick_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        ifrc_out_t e;
        e = tick_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); errors++;
        end
        if (out_data.control_freq !== e.control_freq) begin
          $error("control_freq exp %h got %h", e.control_freq, out_data.control_freq);
          errors++;
        end
        if (out_data.angular_freq !== e.angular_freq) begin
          $error("angular_freq exp %h got %h", e.angular_freq, out_data.angular_freq);
          errors++;
        end
        if (out_data.phase_time_out !== e.phase_time_out) begin
          $error("phase_time_out exp %h got %h", e.phase_time_out, out_data.phase_time_out);
          errors++;
        end
        if (out_data.free_running !== e.free_running) begin
          $error("free_running exp %0d got %0d", e.free_running, out_data.free_running);
          errors++;
        end
      end
    end
  end

  function automatic ifrc_in_t mk(bit b, bit c, logic [31:0] st, bit re,
                                  logic [31:0] ph, bit qt);
    ifrc_in_t it;
    it.braking = b; it.coasting = c; it.angular_step = st;
    it.rescale_enable = re; it.phase_time_in = ph; it.quit = qt;
    return it;
  endfunction

  function automatic ifrc_out_t mo(bit s, logic [31:0] cf, logic [31:0] af,
                                   logic [31:0] ph, bit fr);
    ifrc_out_t o;
    o.status = s; o.control_freq = cf; o.angular_freq = af;
    o.phase_time_out = ph; o.free_running = fr;
    return o;
  endfunction

  // random item: mostly ramp-like steps, some wild
  function automatic ifrc_in_t rand_tick();
    ifrc_in_t it;
    int k;
    it = mk(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
            1'($urandom_range(1)), $urandom, 1'b0);
    k = $urandom_range(9);
    if (k < 6) it.angular_step = $signed(32'($urandom_range(8192))) - 32'sd4096 + 32'sd65536 * (k < 2);
    else if (k < 8) it.angular_step = $signed($urandom) >>> $urandom_range(31);
    it.quit = ($urandom_range(9) == 0);
    if ($urandom_range(3) == 0) it.phase_time_in = $urandom >> $urandom_range(31);
    return it;
  endfunction

  typedef struct {
    ifrc_in_t  stim;
    bit        typed;
    ifrc_out_t result;
  } tick_row_t;

  tick_row_t rows [$];
  ifrc_out_t nil_out;

  initial begin
    errors = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    rst = 1'b1; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_valid = 1'b0; in_data = '0;
    foreach (ramp_regs[i]) ramp_regs[i] = '0;
    ang_q = '0; ctl_q = '0; frun_q = 1'b0;
    nil_out = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part: all registers zero after reset
    rows.push_back('{mk(0, 0, 32'h0001_0000, 1, 32'h1234_5678, 0), 1,
                     mo(1, 32'd10430, 32'h0001_0000, 32'h0, 0)});
    rows.push_back('{mk(0, 0, 32'h0001_0000, 1, 32'h8000_0000, 1), 1,
                     mo(0, 32'd10430, 32'h0002_0000, 32'h4000_0000, 0)});
    rows.push_back('{mk(1, 0, 32'h8000_0000, 1, 32'hFFFF_FFFF, 0), 1,
                     mo(1, 32'h0, 32'h0, 32'h0, 0)});
    rows.push_back('{mk(0, 0, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 0), 0, nil_out});
    rows.push_back('{mk(0, 0, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 0), 0, nil_out});
    rows.push_back('{mk(0, 0, 32'h7FFF_FFFF, 0, 32'h0000_0001, 0), 0, nil_out});
    rows.push_back('{mk(0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0), 0, nil_out});
    rows.push_back('{mk(1, 1, 32'h8000_0000, 1, 32'h0000_0001, 0), 0, nil_out});
    rows.push_back('{mk(0, 1, 32'h0010_0000, 1, 32'hFFFF_FFFF, 0), 0, nil_out});
    rows.push_back('{mk(1, 0, 32'h0010_0000, 1, 32'hFFFF_FFFF, 1), 0, nil_out});
    rows.push_back('{mk(0, 0, 32'h0000_0000, 0, 32'h0000_0000, 0), 0, nil_out});
    foreach (rows[i]) send_tick(rows[i].stim, rows[i].typed, rows[i].result);
    drain();

    // free-run paths with mostly small rates and ceilings, and a bad index write
    write_reg(REG_ACCEL_ON_RATE, 32'h0000_0100);
    write_reg(REG_ACCEL_ON_MAX, 32'h0001_0000);
    write_reg(REG_ACCEL_OFF_RATE, 32'h0000_4000);
    write_reg(REG_ACCEL_OFF_MAX, 32'h0000_8000);
    write_reg(REG_BRAKE_ON_RATE, 32'h0002_0000);
    write_reg(REG_BRAKE_ON_MAX, 32'hFFFF_FFFF);
    write_reg(REG_BRAKE_OFF_RATE, 32'h0000_0001);
    write_reg(REG_BRAKE_OFF_MAX, 32'h0000_0000);
    write_reg(REG_BAD, 32'hDEAD_BEEF);
    for (int i = 0; i < 12; i++)
      send_tick(mk(i[0], i < 6, 32'h0004_0000, 1, 32'h0100_0000, i == 3), 0, nil_out);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      case (ph)
        0: write_all(32'h0, 32'h0);
        1: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: for (int r = 0; r < 8; r++) write_reg(4'(r), $urandom >> $urandom_range(31));
        default: for (int r = 0; r < 8; r++) write_reg(4'(r), $urandom >> $urandom_range(16, 31));
      endcase
      if (ph == 2) hold_cycles = 600;  // long hold-off stalls the block with its result held
      for (int n = 0; n < 200; n++) send_tick(rand_tick(), 0, nil_out);
      drain();
    end

    if (errors == 0 && tick_results.size() == 0) begin
      $display("inverter_frequency_ramp_control_unit_tb passed");
    end else begin
      $display("inverter_frequency_ramp_control_unit_tb failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ifrc_pkg.sv
rtl/core/ifrc_datapath.sv
rtl/core/ifrc_ctrl.sv
rtl/core/inverter_frequency_ramp_control_unit.sv
rtl/core/ifrc_checker.sv
test/inverter_frequency_ramp_control_unit_tb.sv
